FILE: rtl/core/mrpc_pkg.sv
// Shared types, op codes and register indexes for the motor ramp position controller.
`default_nettype none

package mrpc_pkg;

  localparam int unsigned OpW    = 3;
  localparam int unsigned SpeedW = 8;
  localparam int unsigned PosW   = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // Operation codes carried in the op field
  localparam logic [OpW-1:0] OP_TICK   = 3'd0;
  localparam logic [OpW-1:0] OP_START  = 3'd1;
  localparam logic [OpW-1:0] OP_STOP   = 3'd2;
  localparam logic [OpW-1:0] OP_TOGGLE = 3'd3;
  localparam logic [OpW-1:0] OP_GOTO   = 3'd4;
  localparam logic [OpW-1:0] OP_CENTER = 3'd5;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CFG_START_SPEED = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_SPEED   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_STEP_UP     = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_STEP_DOWN   = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_CENTER_POS  = 3'd4;

  localparam logic DIR_FWD = 1'b1;
  localparam logic DIR_REV = 1'b0;

  typedef struct packed {
    logic [OpW-1:0]         op;
    logic                   dir;
    logic signed [PosW-1:0] goal_position;
    logic signed [PosW-1:0] encoder_position;
    logic signed [PosW-1:0] forward_limit;
    logic signed [PosW-1:0] reverse_limit;
    logic                   on_center;
  } in_item_t;

  typedef struct packed {
    logic [SpeedW-1:0] duty;
    logic              pwm_on;
    logic              dir_out;
    logic              count_enable;
    logic              count_dir;
    logic              started;
    logic              moving;
  } out_item_t;

  // Pipeline control between the input register and the core
  typedef struct packed {
    logic valid;
    logic advance;
  } stage_ctl_t;

endpackage : mrpc_pkg

`default_nettype wire

FILE: rtl/core/motor_ramp_position_controller_unit.sv
// Top level of the motor ramp position controller.
`default_nettype none

// Motor ramp position controller. Every input transaction is a tick or a
// command (start, stop, toggle, goto position, find center) together with
// the encoder count, both travel limits and the center sensor; each yields
// exactly one result transaction showing the PWM duty, PWM enable, direction
// pin, encoder counting controls and the started/moving flags after that item.
// Throughput is one transaction per clock while the result side does not
// stall: the item sits in an input register, the update logic (a few 16-bit
// compares, 8-bit adds/subtracts and compares against the step sizes) runs
// in that same cycle, and the controller state and the result register load
// together at the next edge. The result appears once the item has moved from
// the input register into the result register. Backpressure
// on the result side stalls the input register, so in_ready follows
// out_ready combinationally when both stages are full. Configuration writes
// (cfg_we, cfg_index, cfg_wdata) take effect at the edge they are presented
// and are expected only while no transaction is in flight; indexes 0..4 are
// start_speed, max_speed, step_up, step_down and center_position, others are
// ignored.
module motor_ramp_position_controller_unit
  import mrpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  in_item_t            in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output out_item_t           out_data
);

  stage_ctl_t ctl;
  in_item_t   item;
  out_item_t  result;
  logic       can_load;

  mrpc_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (can_load),
    .ctl      (ctl),
    .item     (item)
  );

  // State commits exactly when the item moves into the result register
  mrpc_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .ctl       (ctl),
    .item      (item),
    .result    (result)
  );

  mrpc_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (ctl.advance),
    .result    (result),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule : motor_ramp_position_controller_unit

`default_nettype wire

FILE: rtl/core/mrpc_in_stage.sv
// Input register stage with valid/ready handshake.
`default_nettype none

module mrpc_in_stage
  import mrpc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_data,
  input  logic       advance,
  output stage_ctl_t ctl,
  output in_item_t   item
);

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  // Stage frees up when empty or when its item moves on this cycle
  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign ctl.valid   = valid_r;
  assign ctl.advance = valid_r && advance;
  assign item        = item_r;

endmodule : mrpc_in_stage

`default_nettype wire

FILE: rtl/core/mrpc_core.sv
// Controller state, configuration registers and per-item update logic.
`default_nettype none

module mrpc_core
  import mrpc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_wdata,
  input  stage_ctl_t          ctl,
  input  in_item_t            item,
  output out_item_t           result
);

  // Configuration
  logic [SpeedW-1:0]      start_speed_r, max_speed_r, step_up_r, step_down_r;
  logic signed [PosW-1:0] center_pos_r;

  // Controller state
  logic [SpeedW-1:0]      duty_r, duty_nxt;
  logic [SpeedW-1:0]      tgt_speed_r, tgt_speed_nxt;
  logic                   tgt_dir_r, tgt_dir_nxt;
  logic                   pin_dir_r, pin_dir_nxt;
  logic                   goto_act_r, goto_act_nxt;
  logic                   seek_r, seek_nxt;
  logic signed [PosW-1:0] goto_tgt_r, goto_tgt_nxt;
  logic                   pwm_en_r, pwm_en_nxt;
  logic                   cnt_on_r, cnt_on_nxt;
  logic                   cnt_dir_r, cnt_dir_nxt;

  // Working signals
  logic signed [PosW-1:0] enc, fl, rl, goal, fl_eff, rl_eff, goto_pos;
  logic                   do_start, start_dir, do_stop, do_goto, hit;
  logic [SpeedW-1:0]      tsp, diff;

  assign enc  = item.encoder_position;
  assign fl   = item.forward_limit;
  assign rl   = item.reverse_limit;
  assign goal = item.goal_position;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_speed_r <= '0;
      max_speed_r   <= '1;
      step_up_r     <= SpeedW'(1);
      step_down_r   <= SpeedW'(1);
      center_pos_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_SPEED: start_speed_r <= cfg_wdata[SpeedW-1:0];
        CFG_MAX_SPEED:   max_speed_r   <= cfg_wdata[SpeedW-1:0];
        CFG_STEP_UP:     step_up_r     <= cfg_wdata[SpeedW-1:0];
        CFG_STEP_DOWN:   step_down_r   <= cfg_wdata[SpeedW-1:0];
        CFG_CENTER_POS:  center_pos_r  <= cfg_wdata[PosW-1:0];
        default: ;
      endcase
    end
  end

  // Command decode: which of start / stop / goto this item performs
  always_comb begin
    do_start  = 1'b0;
    start_dir = item.dir;
    do_stop   = 1'b0;
    do_goto   = 1'b0;
    goto_pos  = goal;
    case (item.op)
      OP_START: do_start = 1'b1;
      OP_STOP:  do_stop  = 1'b1;
      OP_TOGGLE: begin
        if (tgt_speed_r > start_speed_r) begin
          do_stop = 1'b1;
        end else begin
          do_start = 1'b1;
        end
      end
      OP_GOTO, OP_CENTER: begin
        if (item.op == OP_CENTER) begin
          goto_pos = center_pos_r;
        end
        if (goto_pos != enc) begin
          do_goto   = 1'b1;
          do_start  = 1'b1;
          start_dir = (goto_pos > enc) ? DIR_FWD : DIR_REV;
        end
      end
      default: ;
    endcase
  end

  // Tick: limit / goto / center stop check
  assign fl_eff = (goto_act_r && !seek_r) ? goto_tgt_r : fl;
  assign rl_eff = (goto_act_r && !seek_r) ? goto_tgt_r : rl;
  assign hit    = (tgt_dir_r == DIR_FWD && enc >= fl_eff) ||
                  (tgt_dir_r == DIR_REV && enc <= rl_eff) ||
                  (seek_r && item.on_center);
  assign tsp    = (tgt_dir_r != pin_dir_r) ? start_speed_r :
                  (hit ? start_speed_r : tgt_speed_r);
  assign diff   = (duty_r < tsp) ? (tsp - duty_r) : (duty_r - tsp);

  always_comb begin
    duty_nxt      = duty_r;
    tgt_speed_nxt = tgt_speed_r;
    tgt_dir_nxt   = tgt_dir_r;
    pin_dir_nxt   = pin_dir_r;
    goto_act_nxt  = goto_act_r;
    seek_nxt      = seek_r;
    goto_tgt_nxt  = goto_tgt_r;
    pwm_en_nxt    = pwm_en_r;
    cnt_on_nxt    = cnt_on_r;
    cnt_dir_nxt   = cnt_dir_r;

    if (item.op == OP_TICK) begin
      if (hit) begin
        goto_act_nxt  = 1'b0;
        seek_nxt      = 1'b0;
        tgt_speed_nxt = start_speed_r;
      end
      if (duty_r < tsp) begin
        if (!(duty_r > start_speed_r)) begin
          pwm_en_nxt = 1'b1;
        end
        duty_nxt = (diff < step_up_r) ? tsp : (duty_r + step_up_r);
      end else begin
        duty_nxt = (diff < step_down_r) ? tsp : (duty_r - step_down_r);
        if (duty_nxt <= start_speed_r) begin
          if (tgt_dir_r == pin_dir_r) begin
            pwm_en_nxt  = 1'b0;
            tgt_dir_nxt = DIR_FWD;
            pin_dir_nxt = DIR_FWD;
            cnt_on_nxt  = 1'b0;
          end else begin
            pin_dir_nxt = tgt_dir_r;
            cnt_on_nxt  = 1'b1;
            cnt_dir_nxt = tgt_dir_r;
          end
        end
      end
    end else begin
      if (do_stop) begin
        goto_act_nxt  = 1'b0;
        seek_nxt      = 1'b0;
        tgt_speed_nxt = start_speed_r;
      end
      if (do_start) begin
        goto_act_nxt  = 1'b0;
        seek_nxt      = 1'b0;
        tgt_speed_nxt = max_speed_r;
        tgt_dir_nxt   = start_dir;
        if (!(duty_r > start_speed_r)) begin
          pin_dir_nxt = start_dir;
          cnt_on_nxt  = 1'b1;
          cnt_dir_nxt = start_dir;
        end
      end
      if (do_goto) begin
        goto_act_nxt = 1'b1;
        if (start_dir == DIR_FWD) begin
          goto_tgt_nxt = (goto_pos > fl) ? fl : goto_pos;
        end else begin
          goto_tgt_nxt = (goto_pos < rl) ? rl : goto_pos;
        end
      end
      // Center search flag is set even when already at the center position
      if (item.op == OP_CENTER) begin
        seek_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r      <= '0;
      tgt_speed_r <= '0;
      tgt_dir_r   <= DIR_FWD;
      pin_dir_r   <= DIR_FWD;
      goto_act_r  <= 1'b0;
      seek_r      <= 1'b0;
      goto_tgt_r  <= '0;
      pwm_en_r    <= 1'b0;
      cnt_on_r    <= 1'b0;
      cnt_dir_r   <= DIR_FWD;
    end else if (ctl.advance) begin
      duty_r      <= duty_nxt;
      tgt_speed_r <= tgt_speed_nxt;
      tgt_dir_r   <= tgt_dir_nxt;
      pin_dir_r   <= pin_dir_nxt;
      goto_act_r  <= goto_act_nxt;
      seek_r      <= seek_nxt;
      goto_tgt_r  <= goto_tgt_nxt;
      pwm_en_r    <= pwm_en_nxt;
      cnt_on_r    <= cnt_on_nxt;
      cnt_dir_r   <= cnt_dir_nxt;
    end
  end

  // Result reflects the state after this item
  assign result.duty         = duty_nxt;
  assign result.pwm_on       = pwm_en_nxt;
  assign result.dir_out      = pin_dir_nxt;
  assign result.count_enable = cnt_on_nxt;
  assign result.count_dir    = cnt_dir_nxt;
  assign result.started      = tgt_speed_nxt > start_speed_r;
  assign result.moving       = duty_nxt > start_speed_r;

endmodule : mrpc_core

`default_nettype wire

FILE: rtl/core/mrpc_out_stage.sv
// Result register with valid/ready handshake.
`default_nettype none

module mrpc_out_stage
  import mrpc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  out_item_t result,
  output logic      can_load,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      valid_r, valid_nxt;
  out_item_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign valid_nxt = load ? 1'b1 : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= result;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule : mrpc_out_stage

`default_nettype wire

FILE: rtl/core/mrpc_checker.sv
// Port-level checker for the motor ramp position controller, with its bind.
`default_nettype none

module mrpc_checker
  import mrpc_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_ready,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // Nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With the result register empty the input is always open
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input blocked with empty result register");

  // Counting off only ever leaves the direction pin forward
  a_idle_fwd: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.count_enable |-> out_data.dir_out == DIR_FWD)
    else $error("counting off with reverse pin");

  // Counting direction follows the pin while counting is on
  a_count_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.count_enable |-> out_data.count_dir == out_data.dir_out)
    else $error("count direction differs from pin");

endmodule : mrpc_checker

bind motor_ramp_position_controller_unit mrpc_checker u_mrpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: tb/sv/tb_motor_ramp_position_controller_unit.sv
// Self-checking testbench for motor_ramp_position_controller_unit.
module tb_motor_ramp_position_controller_unit;
  import mrpc_pkg::*;

  // Op codes the block has to ignore
  localparam logic [OpW-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OpW-1:0] OP_SPARE7 = 3'd7;
  // Register index with no register behind it
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 3'd5;

  // Generous watchdog limit for the slowest phases
  localparam int CYCLE_LIMIT = 200000;
  // Receiver hold-off used to fill the pipe and stall the input
  localparam int HOLD_OFF    = 80;
  // Cycles allowed after the last result
  localparam int SETTLE      = 6;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  in_item_t            in_data;
  logic                out_valid;
  logic                out_ready;
  out_item_t           out_data;

  motor_ramp_position_controller_unit uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Mirror of the configuration registers, updated as they are written
  // ---------------------------------------------------------------------
  logic [SpeedW-1:0]      cfg_start;
  logic [SpeedW-1:0]      cfg_max;
  logic [SpeedW-1:0]      cfg_up;
  logic [SpeedW-1:0]      cfg_down;
  logic signed [PosW-1:0] cfg_center;

  // ---------------------------------------------------------------------
  // Motor state as the bench expects it to be
  // ---------------------------------------------------------------------
  logic [SpeedW-1:0]      duty_q;      // PWM compare value
  logic [SpeedW-1:0]      speed_goal;  // speed the ramp heads for
  logic                   head_dir;    // direction we want to travel
  logic                   pin_dir_q;   // direction pin actually driven
  logic                   goto_on;
  logic                   seek_on;     // center search in progress
  logic signed [PosW-1:0] goto_pos;    // clamped goto target
  logic                   pwm_q;
  logic                   cnt_on;
  logic                   cnt_dir_q;

  // Status words still owed by the block, oldest first
  out_item_t status_due[$];

  int mismatches;
  int cycle_count;
  int gap_pct;     // chance per cycle that the sender sits idle
  int stall_pct;   // chance per cycle that the receiver drops ready
  int hold_left;   // cycles left in a forced receiver hold-off

  // Travel window and simulated dome position for the random phases
  int lim_fwd;
  int lim_rev;
  int shaft;

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------
  function automatic void halt_motor();
    goto_on    = 1'b0;
    seek_on    = 1'b0;
    speed_goal = cfg_start;
  endfunction

  function automatic void launch_motor(input logic d);
    goto_on    = 1'b0;
    seek_on    = 1'b0;
    speed_goal = cfg_max;
    head_dir   = d;
    // Pin and counter follow only while the motor counts as stopped;
    // otherwise the reversal waits for the ramp-down on a later tick
    if (!(duty_q > cfg_start)) begin
      pin_dir_q = head_dir;
      cnt_on    = 1'b1;
      cnt_dir_q = head_dir;
    end
  endfunction

  function automatic void aim_at(input logic signed [PosW-1:0] pos, enc, fwd, rev);
    if (pos > enc) begin
      launch_motor(DIR_FWD);
      goto_pos = (pos > fwd) ? fwd : pos;
      goto_on  = 1'b1;
    end else if (pos < enc) begin
      launch_motor(DIR_REV);
      goto_pos = (pos < rev) ? rev : pos;
      goto_on  = 1'b1;
    end
  endfunction

  function automatic void ramp_tick(input logic signed [PosW-1:0] enc, fwd, rev,
                                    input logic ctr);
    logic [SpeedW-1:0] goal;
    // A plain goto uses its target as both limits; a center search keeps
    // the real limits and stops on the sensor instead
    if (goto_on && !seek_on) begin
      fwd = goto_pos;
      rev = goto_pos;
    end
    if ((head_dir == DIR_FWD && enc >= fwd) || (head_dir == DIR_REV && enc <= rev) ||
        (seek_on && ctr))
      halt_motor();
    goal = (head_dir != pin_dir_q) ? cfg_start : speed_goal;
    if (duty_q < goal) begin
      if (!(duty_q > cfg_start))
        pwm_q = 1'b1;
      if ((goal - duty_q) < cfg_up)
        duty_q = goal;
      else
        duty_q = duty_q + cfg_up;
    end else begin
      if ((duty_q - goal) < cfg_down)
        duty_q = goal;
      else
        duty_q = duty_q - cfg_down;
      if (duty_q <= cfg_start) begin
        if (head_dir == pin_dir_q) begin
          // Came to rest: power off and park the direction forward
          pwm_q     = 1'b0;
          head_dir  = DIR_FWD;
          pin_dir_q = DIR_FWD;
          cnt_on    = 1'b0;
        end else begin
          // Slow enough to flip the pin and start the other way
          pin_dir_q = head_dir;
          cnt_on    = 1'b1;
          cnt_dir_q = head_dir;
        end
      end
    end
  endfunction

  function automatic out_item_t apply_item(input in_item_t it);
    out_item_t st;
    logic signed [PosW-1:0] enc;
    logic signed [PosW-1:0] fwd;
    logic signed [PosW-1:0] rev;
    enc = it.encoder_position;
    fwd = it.forward_limit;
    rev = it.reverse_limit;
    case (it.op)
      OP_TICK:   ramp_tick(enc, fwd, rev, it.on_center);
      OP_START:  launch_motor(it.dir);
      OP_STOP:   halt_motor();
      OP_TOGGLE: begin
        if (speed_goal > cfg_start)
          halt_motor();
        else
          launch_motor(it.dir);
      end
      OP_GOTO:   aim_at(it.goal_position, enc, fwd, rev);
      OP_CENTER: begin
        aim_at(cfg_center, enc, fwd, rev);
        seek_on = 1'b1;
      end
      default: ;
    endcase
    st.duty         = duty_q;
    st.pwm_on       = pwm_q;
    st.dir_out      = pin_dir_q;
    st.count_enable = cnt_on;
    st.count_dir    = cnt_dir_q;
    st.started      = speed_goal > cfg_start;
    st.moving       = duty_q > cfg_start;
    return st;
  endfunction

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  function automatic int clip16(input int v);
    if (v > 32767)
      return 32767;
    if (v < -32768)
      return -32768;
    return v;
  endfunction

  function automatic in_item_t mk_item(input logic [OpW-1:0] op, input logic d,
                                       input int goal, enc, fwd, rev,
                                       input logic ctr);
    in_item_t it;
    it.op               = op;
    it.dir              = d;
    it.goal_position    = PosW'(goal);
    it.encoder_position = PosW'(enc);
    it.forward_limit    = PosW'(fwd);
    it.reverse_limit    = PosW'(rev);
    it.on_center        = ctr;
    return it;
  endfunction

  // Mostly well-formed traffic around the simulated dome position, with a
  // few fully random transactions mixed in
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned pick;
    int          goal;
    int          gap;
    pick = $urandom_range(99);
    goal = lim_rev - 300 + int'($urandom_range(lim_fwd - lim_rev + 600));
    gap  = shaft - int'(cfg_center);
    if (gap < 0)
      gap = -gap;
    it = mk_item(OP_TICK, 1'($urandom_range(1)), clip16(goal), shaft, lim_fwd, lim_rev,
                 (gap < 40) || ($urandom_range(49) == 0));
    if (pick < 55)
      it.op = OP_TICK;
    else if (pick < 63)
      it.op = OP_START;
    else if (pick < 68)
      it.op = OP_STOP;
    else if (pick < 75)
      it.op = OP_TOGGLE;
    else if (pick < 85)
      it.op = OP_GOTO;
    else if (pick < 92)
      it.op = OP_CENTER;
    else if (pick < 95)
      it.op = $urandom_range(1) ? OP_SPARE6 : OP_SPARE7;
    else begin
      it.op               = OpW'($urandom_range(7));
      it.goal_position    = PosW'($urandom);
      it.encoder_position = PosW'($urandom);
      it.forward_limit    = PosW'($urandom);
      it.reverse_limit    = PosW'($urandom);
      it.on_center        = 1'($urandom_range(1));
    end
    return it;
  endfunction

  // Offer one transaction; returns at the edge that accepted it
  task automatic send_item(input in_item_t it);
    @(negedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    status_due.push_back(apply_item(it));
  endtask

  // Stop offering and wait for every owed result
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (status_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Only called with the pipe empty
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value[CfgDataW-1:0];
    case (idx)
      CFG_START_SPEED: cfg_start  = value[SpeedW-1:0];
      CFG_MAX_SPEED:   cfg_max    = value[SpeedW-1:0];
      CFG_STEP_UP:     cfg_up     = value[SpeedW-1:0];
      CFG_STEP_DOWN:   cfg_down   = value[SpeedW-1:0];
      CFG_CENTER_POS:  cfg_center = value[PosW-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_profile(input int s, m, u, d, ctr);
    write_reg(CFG_START_SPEED, s);
    write_reg(CFG_MAX_SPEED, m);
    write_reg(CFG_STEP_UP, u);
    write_reg(CFG_STEP_DOWN, d);
    write_reg(CFG_CENTER_POS, ctr);
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Start, stop, toggle and the ignored op codes on a short profile, including
  // a reversal under way and toggle in both senses
  task automatic test_commands();
    set_profile(10, 40, 15, 15, 0);
    write_reg(CFG_UNUSED, 16'hffff);  // must not disturb anything
    send_item(mk_item(OP_TICK, 1, 0, 0, 32767, -32768, 0));
    send_item(mk_item(OP_SPARE6, 1, 0, 0, 32767, -32768, 0));
    send_item(mk_item(OP_SPARE7, 0, -1, -1, -1, -1, 1));
    send_item(mk_item(OP_START, 1, 0, 0, 32767, -32768, 0));
    repeat (3) send_item(mk_item(OP_TICK, 0, 0, 0, 32767, -32768, 0));
    // Reverse while running: ramps down first, then the pin flips
    send_item(mk_item(OP_START, 0, 0, 0, 32767, -32768, 0));
    repeat (3) send_item(mk_item(OP_TICK, 0, 0, 0, 32767, -32768, 0));
    send_item(mk_item(OP_TOGGLE, 1, 0, 0, 32767, -32768, 0));
    send_item(mk_item(OP_TICK, 0, 0, 0, 32767, -32768, 0));
    send_item(mk_item(OP_TOGGLE, 1, 0, 0, 32767, -32768, 0));
    send_item(mk_item(OP_STOP, 0, 0, 0, 32767, -32768, 0));
    drain();
  endtask

  // Goto at the current spot, goto clamped to a limit behind the encoder,
  // goto to the far reverse end, and center search on and off center
  task automatic test_goto_and_center();
    send_item(mk_item(OP_GOTO, 0, 500, 500, 32767, -32768, 0));
    send_item(mk_item(OP_GOTO, 0, 32767, 100, 50, -32768, 0));
    send_item(mk_item(OP_TICK, 0, 0, 100, 50, -32768, 0));
    send_item(mk_item(OP_GOTO, 1, -32768, 0, 32767, -32768, 0));
    send_item(mk_item(OP_TICK, 1, 0, -32768, 32767, -32768, 0));
    send_item(mk_item(OP_CENTER, 0, 0, 0, 32767, -32768, 0));
    send_item(mk_item(OP_TICK, 0, 0, 0, 32767, -32768, 1));
    send_item(mk_item(OP_CENTER, 0, 0, -500, 32767, -32768, 0));
    send_item(mk_item(OP_TICK, 0, 0, -400, 32767, -32768, 0));
    send_item(mk_item(OP_TICK, 0, 0, -300, 32767, -32768, 1));
    drain();
  endtask

  // Zero step sizes freeze the ramp in both directions
  task automatic test_zero_step();
    write_reg(CFG_STEP_UP, 0);
    write_reg(CFG_STEP_DOWN, 0);
    send_item(mk_item(OP_START, 1, 0, 0, 32767, -32768, 0));
    repeat (2) send_item(mk_item(OP_TICK, 0, 0, 0, 32767, -32768, 0));
    send_item(mk_item(OP_STOP, 0, 0, 0, 32767, -32768, 0));
    send_item(mk_item(OP_TICK, 0, 0, 0, 32767, -32768, 0));
    drain();
  endtask

  // One random phase under a given profile and idling mix; the encoder
  // follows the predicted motion so gotos and limits actually get hit
  task automatic test_random_phase(input int gap, stall, s, m, u, d, ctr, count,
                                   input bit full_travel);
    set_profile(s, m, u, d, ctr);
    gap_pct   = gap;
    stall_pct = stall;
    if (full_travel) begin
      lim_fwd = 32767;
      lim_rev = -32768;
    end else begin
      lim_fwd = $urandom_range(6000, 2000);
      lim_rev = -int'($urandom_range(6000, 2000));
    end
    repeat (count) begin
      send_item(random_item());
      if (duty_q > cfg_start)
        shaft = clip16(shaft + (pin_dir_q ? 1 : -1) * int'($urandom_range(60, 1)));
    end
    drain();
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  // Receiver holds off while the sender keeps pushing, so the block fills
  // and has to drop in_ready
  task automatic test_backpressure();
    gap_pct   = 0;
    stall_pct = 0;
    hold_left = HOLD_OFF;
    repeat (24) send_item(random_item());
    drain();
  endtask

  // ---------------------------------------------------------------------
  // Receiver: random ready, or a forced hold-off
  // ---------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // ---------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [7:0] want, got);
    if (got !== want) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (status_due.size() == 0) begin
        $display("%0t: unexpected result transaction expected none got %h",
                 $time, out_data);
        mismatches++;
      end else begin
        want = status_due.pop_front();
        check_field("duty", want.duty, out_data.duty);
        check_field("pwm_on", want.pwm_on, out_data.pwm_on);
        check_field("dir_out", want.dir_out, out_data.dir_out);
        check_field("count_enable", want.count_enable, out_data.count_enable);
        check_field("count_dir", want.count_dir, out_data.count_dir);
        check_field("started", want.started, out_data.started);
        check_field("moving", want.moving, out_data.moving);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------
  initial begin
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_wdata   = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_ready   = 1'b0;
    mismatches  = 0;
    cycle_count = 0;
    gap_pct     = 0;
    stall_pct   = 0;
    hold_left   = 0;
    lim_fwd     = 32767;
    lim_rev     = -32768;
    shaft       = 0;
    // Register and motor state after reset
    cfg_start   = 8'd0;
    cfg_max     = 8'd255;
    cfg_up      = 8'd1;
    cfg_down    = 8'd1;
    cfg_center  = '0;
    duty_q      = '0;
    speed_goal  = 8'd0;
    head_dir    = DIR_FWD;
    pin_dir_q   = DIR_FWD;
    goto_on     = 1'b0;
    seek_on     = 1'b0;
    goto_pos    = '0;
    pwm_q       = 1'b0;
    cnt_on      = 1'b0;
    cnt_dir_q   = DIR_FWD;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_commands();
    test_goto_and_center();
    test_zero_step();
    // Reset-value profile, no idling
    test_random_phase(0, 0, 0, 255, 1, 1, 0, 75, 1'b0);
    // Mid profile, sender mostly idle
    test_random_phase(72, 0, 20, 200, 9, 6, 1500, 75, 1'b0);
    // Largest steps, center at the negative extreme, receiver mostly stalled
    test_random_phase(0, 72, 0, 255, 255, 255, -32768, 75, 1'b1);
    // Start speed at the top and zero max speed: nothing ever counts as moving
    test_random_phase(28, 28, 255, 0, 1, 1, 32767, 75, 1'b0);
    test_random_phase(28, 28, $urandom_range(60), $urandom_range(255, 100),
                      $urandom_range(255, 1), $urandom_range(255, 1),
                      $urandom_range(2000) - 1000, 75, 1'b0);
    test_backpressure();
    test_random_phase(0, 0, 30, 90, 20, 13, 0, 75, 1'b0);

    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
